>>> hdl/ftm_pkg.sv
// ----------------------------------------------------------------------------
// ftm_pkg
// Shared constants for the mono thumbnail downscaler: default target size,
// register map, register reset values, field widths and rgb555 channel positions.
// ----------------------------------------------------------------------------
package ftm_pkg;

    // default thumbnail size
    localparam int unsigned DEF_TARGET_WIDTH  = 48;
    localparam int unsigned DEF_TARGET_HEIGHT = 32;

    // field widths
    localparam int unsigned PIXEL_W     = 16;
    localparam int unsigned CHAN_W      = 5;
    localparam int unsigned LUMA_W      = 7;
    localparam int unsigned SIZE_W      = 10;
    localparam int unsigned ACC_W       = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 10;

    // rgb555 channel positions
    localparam int unsigned RED_LSB   = 10;
    localparam int unsigned GREEN_LSB = 5;
    localparam int unsigned BLUE_LSB  = 0;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH      = 2'd0,
        REG_SRC_HEIGHT     = 2'd1,
        REG_LUMA_THRESHOLD = 2'd2
    } t_cfg_reg;

    // register reset values
    localparam logic [SIZE_W-1:0] RST_SRC_WIDTH      = 10'd160;
    localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT     = 10'd152;
    localparam logic [LUMA_W-1:0] RST_LUMA_THRESHOLD = 7'd24;

endpackage

>>> hdl/ftm_pix_if.sv
// ----------------------------------------------------------------------------
// ftm_pix_if
// Source pixel stream: one rgb555 pixel per transaction plus frame start flag.
// ----------------------------------------------------------------------------
interface ftm_pix_if
    import ftm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [PIXEL_W-1:0]   pixel;
    logic                 frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

>>> hdl/ftm_byte_if.sv
// ----------------------------------------------------------------------------
// ftm_byte_if
// Thumbnail byte stream: one packed byte of up to eight pixels per transaction.
// ----------------------------------------------------------------------------
interface ftm_byte_if
    import ftm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    byte_index;
    logic [BYTE_W-1:0]    byte_value;
    logic                 last_byte;

    modport source (output valid, output byte_index, output byte_value,
                    output last_byte, input ready);
    modport sink   (input valid, input byte_index, input byte_value,
                    input last_byte, output ready);
endinterface

>>> hdl/frame_to_mono_thumbnail.sv
// ----------------------------------------------------------------------------
// frame_to_mono_thumbnail
// Nearest-neighbour downscale of an rgb555 frame to a one-bit thumbnail.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock in raster order and produces the thumbnail
// as packed bytes (bit 0 = leftmost pixel), each byte sent as soon as its
// last sampled pixel arrives. Sustained rate is one pixel per cycle when no
// stall occurs; a byte passes through the input register, then the result
// register. While a byte waits in the result register, pixels that
// complete no byte keep flowing; the input stalls only when the next byte is
// ready and the previous one has not been taken. Sampling positions are
// tracked with running accumulators, one add per pixel and one per line.
// Source width and height below the thumbnail size are treated as the
// thumbnail size. Write the size and threshold registers only while no pixel
// is in flight.
// ----------------------------------------------------------------------------
module frame_to_mono_thumbnail
    import ftm_pkg::*;
#(
    parameter int unsigned TARGET_WIDTH  = DEF_TARGET_WIDTH,
    parameter int unsigned TARGET_HEIGHT = DEF_TARGET_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ftm_pix_if.sink               i_pix,
    ftm_byte_if.source            o_byte
);

    localparam int unsigned TCW = $clog2(TARGET_WIDTH + 1);
    localparam int unsigned TRW = $clog2(TARGET_HEIGHT + 1);
    localparam int unsigned POSW = 9;

    localparam logic [TCW-1:0]   TW_C    = TCW'(TARGET_WIDTH);
    localparam logic [TCW-1:0]   TW_LAST = TCW'(TARGET_WIDTH - 1);
    localparam logic [TRW-1:0]   TH_C    = TRW'(TARGET_HEIGHT);
    localparam logic [TRW-1:0]   TH_LAST = TRW'(TARGET_HEIGHT - 1);
    localparam logic [ACC_W-1:0] TW_ACC  = ACC_W'(TARGET_WIDTH);
    localparam logic [ACC_W-1:0] TH_ACC  = ACC_W'(TARGET_HEIGHT);
    localparam logic [SIZE_W-1:0] TW_SZ  = SIZE_W'(TARGET_WIDTH);
    localparam logic [SIZE_W-1:0] TH_SZ  = SIZE_W'(TARGET_HEIGHT);
    localparam logic [2:0]       TW_MOD8 = 3'(TARGET_WIDTH % 8);

    // configuration registers
    logic [SIZE_W-1:0] r_src_width;
    logic [SIZE_W-1:0] r_src_height;
    logic [LUMA_W-1:0] r_luma_threshold;

    // input register
    logic               r_in_valid;
    logic [PIXEL_W-1:0] r_in_pixel;
    logic               r_in_frame_start;

    // position state
    logic [SIZE_W-1:0] r_src_col,  n_src_col;
    logic [SIZE_W-1:0] r_src_row,  n_src_row;
    logic [TCW-1:0]    r_tgt_col,  n_tgt_col;
    logic [TRW-1:0]    r_tgt_row,  n_tgt_row;
    logic [ACC_W-1:0]  r_col_acc,  n_col_acc;
    logic [ACC_W-1:0]  r_row_acc,  n_row_acc;
    logic [BYTE_W-1:0] r_bits,     n_bits;
    logic [BYTE_W-1:0] r_byte_cnt, n_byte_cnt;

    // result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_index;
    logic [BYTE_W-1:0] r_out_value;
    logic              r_out_last;

    // datapath signals
    logic              advance;
    logic              consume;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [SIZE_W-1:0] c_src_col, c_src_row;
    logic [TCW-1:0]    c_tgt_col;
    logic [TRW-1:0]    c_tgt_row;
    logic [ACC_W-1:0]  c_col_acc, c_row_acc;
    logic [BYTE_W-1:0] c_bits, c_byte_cnt;
    logic              row_hit, col_active, col_hit, sample;
    logic [LUMA_W-1:0] luma;
    logic              bright;
    logic [POSW-1:0]   row_ext, col_ext;
    logic [2:0]        pos;
    logic              is_last;
    logic [BYTE_W-1:0] collected;
    logic              emit;
    logic [SIZE_W-1:0] col_inc, row_inc;
    logic              line_end, frame_end;

    // handshake: a pixel that completes no byte never waits for the result register
    assign advance     = !r_out_valid || o_byte.ready;
    assign consume     = r_in_valid && (advance || !emit);
    assign i_pix.ready = !r_in_valid || consume;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width      <= RST_SRC_WIDTH;
            r_src_height     <= RST_SRC_HEIGHT;
            r_luma_threshold <= RST_LUMA_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SRC_WIDTH:      r_src_width      <= i_cfg_data;
                REG_SRC_HEIGHT:     r_src_height     <= i_cfg_data;
                REG_LUMA_THRESHOLD: r_luma_threshold <= i_cfg_data[LUMA_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_in_pixel       <= i_pix.pixel;
            r_in_frame_start <= i_pix.frame_start;
        end
    end

    // effective source size, saturated up to the thumbnail size
    assign w_eff = (r_src_width  < TW_SZ) ? TW_SZ : r_src_width;
    assign h_eff = (r_src_height < TH_SZ) ? TH_SZ : r_src_height;

    // frame start clears the position state before the pixel is used
    always_comb begin
        if (r_in_frame_start) begin
            c_src_col  = '0;
            c_src_row  = '0;
            c_tgt_col  = '0;
            c_tgt_row  = '0;
            c_col_acc  = '0;
            c_row_acc  = '0;
            c_bits     = '0;
            c_byte_cnt = '0;
        end else begin
            c_src_col  = r_src_col;
            c_src_row  = r_src_row;
            c_tgt_col  = r_tgt_col;
            c_tgt_row  = r_tgt_row;
            c_col_acc  = r_col_acc;
            c_row_acc  = r_row_acc;
            c_bits     = r_bits;
            c_byte_cnt = r_byte_cnt;
        end
    end

    // sampling decision and luma threshold
    assign row_hit    = (c_tgt_row < TH_C) && (c_row_acc < TH_ACC);
    assign col_active = c_tgt_col < TW_C;
    assign col_hit    = col_active && (c_col_acc < TW_ACC);
    assign sample     = row_hit && col_hit;

    assign luma = LUMA_W'(r_in_pixel[RED_LSB   +: CHAN_W])
                + LUMA_W'(r_in_pixel[GREEN_LSB +: CHAN_W])
                + LUMA_W'(r_in_pixel[BLUE_LSB  +: CHAN_W]);
    assign bright = luma >= r_luma_threshold;

    // bit position within the byte: (row * width + col) mod 8
    assign row_ext = POSW'(c_tgt_row);
    assign col_ext = POSW'(c_tgt_col);
    assign pos     = 3'(row_ext[2:0] * TW_MOD8) + col_ext[2:0];
    assign is_last = (c_tgt_row == TH_LAST) && (c_tgt_col == TW_LAST);

    assign collected = c_bits | (BYTE_W'(bright) << pos);
    assign emit      = sample && ((pos == 3'd7) || is_last);

    // next position state
    always_comb begin
        n_tgt_col  = c_tgt_col;
        n_tgt_row  = c_tgt_row;
        n_col_acc  = c_col_acc;
        n_row_acc  = c_row_acc;
        n_src_row  = c_src_row;
        n_bits     = c_bits;
        n_byte_cnt = c_byte_cnt;
        row_inc    = '0;

        // collector and byte count
        if (sample) begin
            n_bits = collected;
        end
        if (emit) begin
            n_bits     = '0;
            n_byte_cnt = c_byte_cnt + 1'b1;
        end

        // column tracking
        if (col_active) begin
            n_col_acc = c_col_acc + (col_hit ? ACC_W'(w_eff) : '0) - TW_ACC;
            n_tgt_col = c_tgt_col + TCW'(col_hit);
        end
        col_inc   = c_src_col + 1'b1;
        n_src_col = col_inc;
        line_end  = (col_inc >= w_eff) || (col_inc == '0);
        frame_end = 1'b0;

        // end of source line: row tracking
        if (line_end) begin
            n_src_col = '0;
            n_tgt_col = '0;
            n_col_acc = '0;
            if (c_tgt_row < TH_C) begin
                n_row_acc = c_row_acc + (row_hit ? ACC_W'(h_eff) : '0) - TH_ACC;
                n_tgt_row = c_tgt_row + TRW'(row_hit);
            end
            row_inc   = c_src_row + 1'b1;
            n_src_row = row_inc;
            frame_end = (row_inc >= h_eff) || (row_inc == '0);
        end

        // end of source frame: everything wraps
        if (frame_end) begin
            n_src_col  = '0;
            n_src_row  = '0;
            n_tgt_col  = '0;
            n_tgt_row  = '0;
            n_col_acc  = '0;
            n_row_acc  = '0;
            n_bits     = '0;
            n_byte_cnt = '0;
        end
    end

    // position state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_tgt_col  <= '0;
            r_tgt_row  <= '0;
            r_col_acc  <= '0;
            r_row_acc  <= '0;
            r_bits     <= '0;
            r_byte_cnt <= '0;
        end else if (consume) begin
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_tgt_col  <= n_tgt_col;
            r_tgt_row  <= n_tgt_row;
            r_col_acc  <= n_col_acc;
            r_row_acc  <= n_row_acc;
            r_bits     <= n_bits;
            r_byte_cnt <= n_byte_cnt;
        end
    end

    // result register: loaded by a completed byte, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_byte.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && emit) begin
            r_out_index <= c_byte_cnt;
            r_out_value <= collected;
            r_out_last  <= is_last;
        end
    end

    assign o_byte.valid      = r_out_valid;
    assign o_byte.byte_index = r_out_index;
    assign o_byte.byte_value = r_out_value;
    assign o_byte.last_byte  = r_out_last;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mono thumbnail downscaler. A local model of the
// column/row sampling accumulators, the luma threshold and the byte packing
// predicts every thumbnail byte from the accepted pixels. Bytes are checked
// in order as they leave the block. Runs cover the reset sizes, a complete
// frame with frame wrap, small and large source sizes, size changes within a
// frame, random frame restarts and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top
    import ftm_pkg::*;
;

    localparam int unsigned TW          = DEF_TARGET_WIDTH;
    localparam int unsigned TH          = DEF_TARGET_HEIGHT;
    localparam int unsigned FRAME_PIX   = TW * TH;
    localparam int unsigned SETTLE_GAP  = 8;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned PRINT_LIMIT = 40;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] value;
        logic              is_last;
    } t_thumb_byte;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_reg i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ftm_pix_if  pix_bus ();
    ftm_byte_if byte_bus ();

    frame_to_mono_thumbnail u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_bus),
        .o_byte      (byte_bus)
    );

    // register copies seen by the model
    logic [SIZE_W-1:0] thumb_src_width  = RST_SRC_WIDTH;
    logic [SIZE_W-1:0] thumb_src_height = RST_SRC_HEIGHT;
    logic [LUMA_W-1:0] thumb_threshold  = RST_LUMA_THRESHOLD;

    // sampling position state; target counters wide enough to hold the end count
    logic [SIZE_W-1:0] src_col;
    logic [SIZE_W-1:0] src_row;
    logic [6:0]        tgt_col;
    logic [5:0]        tgt_row;
    logic [ACC_W-1:0]  col_acc;
    logic [ACC_W-1:0]  row_acc;
    logic [BYTE_W-1:0] bit_pack;
    logic [BYTE_W-1:0] byte_count;

    t_thumb_byte pending_bytes[$];

    int unsigned error_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned quiet_cycles  = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_position();
        src_col    = '0;
        src_row    = '0;
        tgt_col    = '0;
        tgt_row    = '0;
        col_acc    = '0;
        row_acc    = '0;
        bit_pack   = '0;
        byte_count = '0;
    endfunction

    // one source pixel through the downscaler; queues the byte it completes
    function automatic void advance_thumbnail(input logic [PIXEL_W-1:0] px, input logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned lum;
        int unsigned pos;
        logic row_hit;
        logic col_active;
        logic col_hit;
        logic at_end;
        t_thumb_byte b;
        w = (thumb_src_width < TW) ? TW : thumb_src_width;
        h = (thumb_src_height < TH) ? TH : thumb_src_height;
        if (fs)
            clear_position();

        row_hit    = (tgt_row < TH) && (row_acc < TH);
        col_active = (tgt_col < TW);
        col_hit    = col_active && (col_acc < TW);

        // sample, threshold and pack
        if (row_hit && col_hit) begin
            lum = px[RED_LSB +: CHAN_W] + px[GREEN_LSB +: CHAN_W] + px[BLUE_LSB +: CHAN_W];
            pos = (tgt_row * TW + tgt_col) & 7;
            at_end = (tgt_row == TH - 1) && (tgt_col == TW - 1);
            if (lum >= thumb_threshold)
                bit_pack[pos] = 1'b1;
            if (pos == 7 || at_end) begin
                b.idx     = byte_count;
                b.value   = bit_pack;
                b.is_last = at_end;
                pending_bytes.push_back(b);
                byte_count = byte_count + 1'b1;
                bit_pack   = '0;
            end
        end

        // column step
        if (col_active) begin
            if (col_hit) begin
                col_acc = col_acc + ACC_W'(w);
                tgt_col = tgt_col + 1'b1;
            end
            col_acc = col_acc - ACC_W'(TW);
        end
        src_col = src_col + 1'b1;

        // end of line, possibly end of frame
        if (src_col >= w || src_col == 0) begin
            src_col = '0;
            tgt_col = '0;
            col_acc = '0;
            if (tgt_row < TH) begin
                if (row_hit) begin
                    row_acc = row_acc + ACC_W'(h);
                    tgt_row = tgt_row + 1'b1;
                end
                row_acc = row_acc - ACC_W'(TH);
            end
            src_row = src_row + 1'b1;
            if (src_row >= h || src_row == 0)
                clear_position();
        end
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // predict on every accepted pixel transaction
    always @(posedge i_clk) begin
        if (i_rst_n && pix_bus.valid && pix_bus.ready)
            advance_thumbnail(pix_bus.pixel, pix_bus.frame_start);
    end

    // check every accepted byte transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_thumb_byte want;
        if (i_rst_n && byte_bus.valid === 1'b1 && byte_bus.ready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte idx %0d val %02h",
                                          byte_bus.byte_index, byte_bus.byte_value));
            end else begin
                want = pending_bytes.pop_front();
                if (byte_bus.byte_index !== want.idx || byte_bus.byte_value !== want.value ||
                    byte_bus.last_byte !== want.is_last)
                    report_mismatch($sformatf(
                        "got idx %0d val %02h last %0b, want idx %0d val %02h last %0b",
                        byte_bus.byte_index, byte_bus.byte_value, byte_bus.last_byte,
                        want.idx, want.value, want.is_last));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (byte_bus.valid && byte_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("FAIL frame_to_mono_thumbnail");
            $finish;
        end
    end

    // receiver ready with random stalls and requested hold-offs
    initial begin : receiver_ready
        int unsigned hold_left;
        int unsigned holds_served;
        hold_left      = 0;
        holds_served   = 0;
        byte_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                byte_bus.ready <= 1'b0;
            end else begin
                byte_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic void set_idling(input t_idle_phase phase);
        case (phase)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 84;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 84;
            end
            default: begin
                send_idle_pct  = 26;
                recv_stall_pct = 26;
            end
        endcase
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_W'($urandom_range(16'hffff));
        endcase
    endfunction

    // one pixel transaction, entered and left at a falling edge
    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel       <= px;
        pix_bus.frame_start <= fs;
        do @(posedge i_clk); while (!pix_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic send_pixels(input int unsigned count, input bit open_frame,
                               input int unsigned restart_pct);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(random_pixel(),
                       (open_frame && i == 0) || ($urandom_range(99) < restart_pct));
    endtask

    // stop sending, drain predicted bytes, let the pipeline empty
    task automatic settle();
        pix_bus.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    // write all three registers while the block is idle
    task automatic configure(input logic [SIZE_W-1:0] width, input logic [SIZE_W-1:0] height,
                             input logic [LUMA_W-1:0] thresh);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SRC_WIDTH;
        i_cfg_data  <= width;
        @(negedge i_clk);
        i_cfg_index <= REG_SRC_HEIGHT;
        i_cfg_data  <= height;
        @(negedge i_clk);
        i_cfg_index <= REG_LUMA_THRESHOLD;
        i_cfg_data  <= CFG_DATA_W'(thresh);
        @(negedge i_clk);
        i_cfg_we         <= 1'b0;
        thumb_src_width  = width;
        thumb_src_height = height;
        thumb_threshold  = thresh;
    endtask

    // corner pixels at the reset sizes and threshold
    task automatic test_reset_defaults();
        logic [PIXEL_W-1:0] px;
        set_idling(IDLE_NONE);
        for (int i = 0; i < 25; i++) begin
            case (i % 10)
                0:       px = 16'h0000;
                1:       px = 16'hffff;
                2:       px = 16'h7fff;
                3:       px = 16'h8000;
                4:       px = 16'h7c00;   // red only
                5:       px = 16'h03e0;   // green only
                6:       px = 16'h001f;   // blue only
                7:       px = 16'h2108;   // sum exactly at reset threshold
                8:       px = 16'h2107;   // one below
                default: px = 16'hffe0;
            endcase
            send_pixel(px, i == 0);
        end
    endtask

    // complete minimum-size frame across all idling phases, then wrap into the next
    task automatic test_full_frame();
        configure(SIZE_W'(TW), SIZE_W'(TH), LUMA_W'($urandom_range(10, 60)));
        for (int p = 0; p < 4; p++) begin
            set_idling(t_idle_phase'(p));
            send_pixels(FRAME_PIX / 4, p == 0, 0);
        end
        set_idling(IDLE_NONE);
        send_pixels(16, 1'b0, 0);
    endtask

    // sizes below the thumbnail size saturate up; threshold extremes
    task automatic test_small_sizes();
        set_idling(t_idle_phase'($urandom_range(3)));
        configure('0, '0, '0);
        send_pixels(24, 1'b1, 0);
        configure(SIZE_W'(TW - 1), SIZE_W'(TH - 1), '1);
        send_pixels(16, 1'b0, 0);
    endtask

    task automatic test_large_sizes();
        set_idling(t_idle_phase'($urandom_range(3)));
        configure('1, '1, LUMA_W'(93));
        send_pixels(24, 1'b1, 0);
        configure(SIZE_W'($urandom_range(TW, 1023)), SIZE_W'($urandom_range(TH, 1023)),
                  LUMA_W'($urandom_range(127)));
        send_pixels(16, 1'b0, 0);
    endtask

    // shrink the width inside a frame, twice below the current column
    task automatic test_size_change();
        set_idling(t_idle_phase'($urandom_range(3)));
        configure(SIZE_W'(100), SIZE_W'(40), LUMA_W'(40));
        send_pixels(80, 1'b1, 0);
        configure(SIZE_W'(60), SIZE_W'(40), LUMA_W'(40));
        send_pixels(56, 1'b0, 0);
        configure(SIZE_W'(TW + 1), SIZE_W'(TH + 1), LUMA_W'($urandom_range(20, 60)));
        send_pixels(16, 1'b0, 0);
    endtask

    // random frame starts that drop partly built bytes
    task automatic test_frame_restart();
        set_idling(t_idle_phase'($urandom_range(3)));
        configure(SIZE_W'(56), SIZE_W'(TH), LUMA_W'($urandom_range(127)));
        send_pixels(64, 1'b1, 5);
    endtask

    // long receiver hold-off while pixels keep coming
    task automatic test_backpressure();
        set_idling(IDLE_NONE);
        configure(SIZE_W'(TW), SIZE_W'(TH), LUMA_W'($urandom_range(20, 60)));
        send_pixels(8, 1'b1, 0);
        hold_requests++;
        send_pixels(40, 1'b0, 0);
    endtask

    // main sequence
    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = REG_SRC_WIDTH;
        i_cfg_data          = '0;
        pix_bus.valid       = 1'b0;
        pix_bus.pixel       = '0;
        pix_bus.frame_start = 1'b0;
        clear_position();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_full_frame();
        test_small_sizes();
        test_large_sizes();
        test_size_change();
        test_frame_restart();
        test_backpressure();

        set_idling(IDLE_NONE);
        settle();
        repeat (12) @(negedge i_clk);
        if (error_count == 0 && pending_bytes.size() == 0)
            $display("PASS frame_to_mono_thumbnail");
        else
            $display("FAIL frame_to_mono_thumbnail");
        $finish;
    end

endmodule
